### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the I2C master bit sequencer.
// No dependencies; pulled in by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define A_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define A_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### hw/rtl/i2cms_pkg.sv
// Package for the I2C master bit sequencer: command codes, phase codes,
// register indexes, widths and the state / result structs. No dependencies.
package i2cms_pkg;

    localparam int PHASE_W = 16;
    localparam int ACKTO_W = 10;

    localparam logic [2:0] OP_NONE    = 3'd0;
    localparam logic [2:0] OP_START   = 3'd1;
    localparam logic [2:0] OP_STOP    = 3'd2;
    localparam logic [2:0] OP_SEND    = 3'd3;
    localparam logic [2:0] OP_WAITACK = 3'd4;
    localparam logic [2:0] OP_RECV    = 3'd5;
    localparam logic [2:0] OP_ACK     = 3'd6;
    localparam logic [2:0] OP_NACK    = 3'd7;

    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_ONE   = 4'd1;
    localparam logic [3:0] PH_TWO   = 4'd2;
    localparam logic [3:0] PH_THREE = 4'd3;
    localparam logic [3:0] PH_FINAL = 4'd15;

    // configuration register indexes
    localparam logic CFG_PHASE_TICKS = 1'b0;
    localparam logic CFG_ACK_TIMEOUT = 1'b1;

    localparam logic [PHASE_W-1:0] PHASE_TICKS_RST = 16'd50;
    localparam logic [ACKTO_W-1:0] ACK_TIMEOUT_RST = 10'd300;

    typedef struct packed {
        logic [3:0]         phase_step;
        logic [2:0]         cmd;
        logic [PHASE_W-1:0] tick_count;
        logic [3:0]         bit_count;
        logic [7:0]         shift_byte;
        logic [ACKTO_W-1:0] ack_wait_count;
        logic               scl;
        logic               sda;
        logic               drive;
        logic               ack_flag;
        logic [7:0]         rx_hold;
    } t_state;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_seen;
        logic       rejected;
    } t_result;

endpackage

### hw/rtl/i2cms_step.sv
// One-tick update of the I2C bit sequencer: current state plus one tick beat
// gives next state and the result beat. Depends on i2cms_pkg.
module i2cms_step (
    input  i2cms_pkg::t_state                 i_state,
    input  logic [2:0]                        i_operation,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_sda_in,
    input  logic [i2cms_pkg::PHASE_W-1:0]     i_phase_ticks,
    input  logic [i2cms_pkg::ACKTO_W-1:0]     i_ack_timeout,
    output i2cms_pkg::t_state                 o_state,
    output i2cms_pkg::t_result                o_result
);
    import i2cms_pkg::*;

    t_state             s;
    logic               run;
    logic               done;
    logic               rej;
    logic [PHASE_W-1:0] len;
    logic [PHASE_W:0]   tick_inc;
    logic [3:0]         bit_inc;
    logic [3:0]         p;

    assign len      = (i_phase_ticks == '0) ? PHASE_W'(1) : i_phase_ticks;
    assign tick_inc = {1'b0, i_state.tick_count} + (PHASE_W+1)'(1);
    assign bit_inc  = i_state.bit_count + 4'd1;

    always_comb begin
        s    = i_state;
        run  = 1'b0;
        done = 1'b0;
        rej  = 1'b0;
        if (i_state.phase_step != PH_IDLE) begin
            rej = (i_operation != OP_NONE);
            run = 1'b1;
        end else if (i_operation != OP_NONE) begin
            s.cmd            = i_operation;
            s.phase_step     = PH_ONE;
            s.tick_count     = '0;
            s.bit_count      = '0;
            s.ack_wait_count = '0;
            s.shift_byte     = (i_operation == OP_SEND) ? i_data_byte : 8'd0;
            run = 1'b1;
        end
        p = s.phase_step;

        if (run) begin
            if (p == PH_FINAL) begin
                // closing tick
                case (s.cmd)
                    OP_ACK, OP_NACK: s.scl = 1'b0;
                    OP_SEND: begin
                        s.scl = 1'b0;
                        s.sda = 1'b1;
                    end
                    OP_RECV: begin
                        s.drive   = 1'b1;
                        s.sda     = 1'b1;
                        s.rx_hold = s.shift_byte;
                    end
                    default: ;
                endcase
                done = 1'b1;
            end else begin
                // pin levels of the current phase
                case (s.cmd)
                    OP_START: begin
                        s.drive = 1'b1;
                        s.scl   = 1'b1;
                        s.sda   = (p == PH_ONE);
                    end
                    OP_STOP: begin
                        s.drive = 1'b1;
                        if (p == PH_ONE) begin
                            s.sda = 1'b0;
                        end else if (p == PH_TWO) begin
                            s.sda = 1'b0;
                            s.scl = 1'b1;
                        end else begin
                            s.sda = 1'b1;
                            s.scl = 1'b1;
                        end
                    end
                    OP_ACK, OP_NACK: begin
                        s.drive = 1'b1;
                        if (p == PH_ONE) begin
                            s.scl = 1'b0;
                        end else if (p == PH_TWO) begin
                            s.scl = 1'b0;
                            s.sda = (s.cmd == OP_NACK);
                        end else begin
                            s.scl = 1'b1;
                        end
                    end
                    OP_SEND: begin
                        s.drive = 1'b1;
                        if (p == PH_ONE) begin
                            s.scl = 1'b0;
                        end else if (p == PH_TWO) begin
                            s.scl = 1'b0;
                            s.sda = s.shift_byte[7];
                        end else begin
                            s.scl = 1'b1;
                        end
                    end
                    OP_WAITACK: begin
                        s.drive = 1'b0;
                        s.sda   = 1'b1;
                        s.scl   = (p != PH_ONE);
                    end
                    OP_RECV: begin
                        s.drive = 1'b0;
                        s.sda   = 1'b1;
                        s.scl   = (p == PH_ONE);
                    end
                    default: ;
                endcase

                if (s.cmd == OP_WAITACK && p == PH_TWO) begin
                    // SCL high: poll for the slave pulling SDA low
                    if (s.tick_count == '0) begin
                        s.tick_count = PHASE_W'(1);
                    end else if (!i_sda_in) begin
                        s.ack_flag = 1'b1;
                        s.scl      = 1'b0;
                        done       = 1'b1;
                    end else if (s.ack_wait_count >= i_ack_timeout) begin
                        s.ack_flag = 1'b0;
                        s.scl      = 1'b0;
                        done       = 1'b1;
                    end else begin
                        s.ack_wait_count = s.ack_wait_count + ACKTO_W'(1);
                    end
                end else if (tick_inc >= {1'b0, len}) begin
                    s.tick_count = '0;
                    if (s.cmd == OP_RECV && p == PH_ONE) begin
                        s.shift_byte = {s.shift_byte[6:0], i_sda_in};
                    end
                    // phase advance
                    case (s.cmd)
                        OP_START: s.phase_step = (p == PH_ONE) ? PH_TWO : PH_FINAL;
                        OP_STOP, OP_ACK, OP_NACK:
                            s.phase_step = (p < PH_THREE) ? p + 4'd1 : PH_FINAL;
                        OP_SEND: begin
                            if (p < PH_THREE) begin
                                s.phase_step = p + 4'd1;
                            end else begin
                                s.shift_byte   = {s.shift_byte[6:0], 1'b0};
                                s.bit_count    = bit_inc;
                                s.phase_step   = bit_inc[3] ? PH_FINAL : PH_ONE;
                            end
                        end
                        OP_WAITACK: s.phase_step = PH_TWO;
                        OP_RECV: begin
                            if (p == PH_ONE) begin
                                s.phase_step = PH_TWO;
                            end else begin
                                s.bit_count  = bit_inc;
                                s.phase_step = bit_inc[3] ? PH_FINAL : PH_ONE;
                            end
                        end
                        default: s.phase_step = PH_FINAL;
                    endcase
                end else begin
                    s.tick_count = tick_inc[PHASE_W-1:0];
                end
            end
        end

        if (done) begin
            s.phase_step = PH_IDLE;
            s.cmd        = OP_NONE;
            s.tick_count = '0;
        end
    end

    assign o_state            = s;
    assign o_result.scl_level = s.scl;
    assign o_result.sda_level = s.sda;
    assign o_result.sda_drive = s.drive;
    assign o_result.busy_res  = (s.phase_step != PH_IDLE);
    assign o_result.done_res  = done;
    assign o_result.read_byte = s.rx_hold;
    assign o_result.ack_seen  = s.ack_flag;
    assign o_result.rejected  = rej;

endmodule

### hw/rtl/i2c_master_bit_sequencer.sv
// I2C master bit sequencer, top level: beat registers, sequencer state,
// configuration registers. Depends on i2cms_pkg, i2cms_step, assert_macros.svh.
//
// Each input beat is one timing tick of the bus engine and carries the sampled
// SDA level; while the engine is idle a beat may also carry a command (start,
// stop, send byte MSB first, wait ack, receive byte, send ack, send nack).
// Every input beat gives exactly one result beat with the SCL/SDA pin levels,
// the SDA output enable, busy/done flags, the last received byte, the last ack
// result and a rejected flag for commands arriving while busy. A tick enters
// an input register, the sequencer state and the result are updated in one
// pass of logic, and the result lands in an output register: one beat per
// clock sustained while the output is not stalled, and each result passes
// the input register and then the output register before it is offered. The
// rate is set by the state update loop, which must see each tick's outcome
// before the next tick. While the output holds an untaken result, one more
// tick is still taken into the input register.
// Phase length (register 0, reset 50, 0 acts as 1) and ack timeout
// (register 1, reset 300) are to be written only while no tick is in flight.
`include "assert_macros.svh"

module i2c_master_bit_sequencer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [i2cms_pkg::PHASE_W-1:0] i_cfg_data,
    // tick input
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [2:0]                    i_operation,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_sda_in,
    // result output
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_scl_level,
    output logic                          o_sda_level,
    output logic                          o_sda_drive,
    output logic                          o_busy_res,
    output logic                          o_done_res,
    output logic [7:0]                    o_read_byte,
    output logic                          o_ack_seen,
    output logic                          o_rejected
);
    import i2cms_pkg::*;

    // configuration
    logic [PHASE_W-1:0] r_phase_ticks;
    logic [ACKTO_W-1:0] r_ack_timeout;

    // input register
    logic       r_in_valid;
    logic [2:0] r_in_op;
    logic [7:0] r_in_data;
    logic       r_in_sda;

    // sequencer state and result register
    t_state  r_st;
    t_state  n_st;
    t_result w_res;
    t_result r_res;
    logic    r_out_valid;

    logic w_in_acc;
    logic w_fire;

    // a held tick moves on when the result slot is empty or being drained
    assign w_fire     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_fire;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RST;
            r_ack_timeout <= ACK_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PHASE_TICKS: r_phase_ticks <= i_cfg_data;
                CFG_ACK_TIMEOUT: r_ack_timeout <= i_cfg_data[ACKTO_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_in_acc || (r_in_valid && !w_fire);
        end
    end

    // payload of the input register, loaded on acceptance only
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_op   <= i_operation;
            r_in_data <= i_data_byte;
            r_in_sda  <= i_sda_in;
        end
    end

    i2cms_step u_step (
        .i_state       (r_st),
        .i_operation   (r_in_op),
        .i_data_byte   (r_in_data),
        .i_sda_in      (r_in_sda),
        .i_phase_ticks (r_phase_ticks),
        .i_ack_timeout (r_ack_timeout),
        .o_state       (n_st),
        .o_result      (w_res)
    );

    // sequencer state: pins idle released high and driven
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.phase_step     <= PH_IDLE;
            r_st.cmd            <= OP_NONE;
            r_st.tick_count     <= '0;
            r_st.bit_count      <= '0;
            r_st.shift_byte     <= '0;
            r_st.ack_wait_count <= '0;
            r_st.scl            <= 1'b1;
            r_st.sda            <= 1'b1;
            r_st.drive          <= 1'b1;
            r_st.ack_flag       <= 1'b0;
            r_st.rx_hold        <= '0;
        end else if (w_fire) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_scl_level = r_res.scl_level;
    assign o_sda_level = r_res.sda_level;
    assign o_sda_drive = r_res.sda_drive;
    assign o_busy_res  = r_res.busy_res;
    assign o_done_res  = r_res.done_res;
    assign o_read_byte = r_res.read_byte;
    assign o_ack_seen  = r_res.ack_seen;
    assign o_rejected  = r_res.rejected;

    // a tick that cannot move on stays in the input register
    `A_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !w_fire, r_in_valid)
    // every processed tick produces a result beat
    `A_NEXT(a_fire_out, i_clk, i_rst_n, w_fire, r_out_valid)
    // a finishing tick leaves the engine idle
    `A_NEXT(a_done_idle, i_clk, i_rst_n, w_fire && w_res.done_res, r_st.phase_step == PH_IDLE)
    // rejection only happens while a command is running
    `A_IMPL(a_rej_busy, i_clk, i_rst_n, w_fire && w_res.rejected, r_st.phase_step != PH_IDLE)

endmodule
